/* sv/att_pkg.sv */
// Shared types and constants for the accelerometer tilt-angle pipeline.
// Holds the per-lane pipeline word and the one-degree cos/sin walk used for the angle tables.
// No dependencies.
`default_nettype none
package att_pkg;

  localparam int DEG_W      = 7;
  localparam int MAG2_W     = 31;
  localparam int DEN_W      = 32;
  localparam int WORK_BITS  = 62;
  localparam int TBL_DEPTH  = 128;
  localparam logic [DEG_W-1:0] MAX_DEG   = 7'd89;
  localparam logic [DEG_W-1:0] RIGHT_DEG = 7'd90;
  localparam logic [63:0] DEC_DEN  = 64'd1000000000000000000;
  localparam logic [63:0] SIN1_DEC = 64'd17452406437283513;
  localparam logic [63:0] COS1_DEC = 64'd999847695156391239;

  typedef struct packed {
    logic              valid;
    logic [MAG2_W-1:0] mag2;   // numerator axis squared
    logic [DEN_W-1:0]  den;    // sum of the other two axes squared
    logic [DEG_W-1:0]  deg;    // degrees found so far
    logic              neg;    // negate the final magnitude
    logic              zero;   // numerator is zero
    logic              full;   // denominator is zero
  } lane_t;

  typedef logic [63:0] q_arr_t [0:89];

  function automatic logic [63:0] dec_to_q(input logic [63:0] num);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = num;
    for (int i = 0; i < WORK_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= DEC_DEN) begin
        r = r - DEC_DEN;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Q62 walk from (1,0), one degree per step; returns sines or cosines
  function automatic q_arr_t walk(input logic want_sin);
    q_arr_t      res;
    logic [63:0] c1;
    logic [63:0] s1;
    logic [63:0] c;
    logic [63:0] s;
    logic [63:0] nc;
    logic [63:0] t;
    logic [63:0] ns;
    c1 = dec_to_q(COS1_DEC);
    s1 = dec_to_q(SIN1_DEC);
    c  = 64'd1 << WORK_BITS;
    s  = '0;
    for (int k = 0; k < 90; k++) begin
      res[k] = want_sin ? s : c;
      nc = mul_q(c, c1);
      t  = mul_q(s, s1);
      nc = (nc >= t) ? nc - t : 64'd0;
      ns = mul_q(s, c1) + mul_q(c, s1);
      c  = nc;
      s  = ns;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* sv/att_prep.sv */
// Input stage: squares the three axes and forms numerator/denominator per lane.
// Depends on att_pkg.
`default_nettype none
module att_prep (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                valid_in,
  input  wire logic signed [15:0]  accel_x,
  input  wire logic signed [15:0]  accel_y,
  input  wire logic signed [15:0]  accel_z,
  output att_pkg::lane_t           roll_o,
  output att_pkg::lane_t           pitch_o
);

  logic signed [31:0] xx, yy, zz;
  att_pkg::lane_t roll_nxt, pitch_nxt, roll_r, pitch_r;

  always_comb begin
    xx = accel_x * accel_x;
    yy = accel_y * accel_y;
    zz = accel_z * accel_z;
    roll_nxt.valid  = valid_in;
    roll_nxt.mag2   = yy[30:0];
    roll_nxt.den    = xx[31:0] + zz[31:0];
    roll_nxt.deg    = '0;
    roll_nxt.neg    = accel_y[15];
    roll_nxt.zero   = (accel_y == 16'sd0);
    roll_nxt.full   = (accel_x == 16'sd0) && (accel_z == 16'sd0);
    pitch_nxt.valid = valid_in;
    pitch_nxt.mag2  = xx[30:0];
    pitch_nxt.den   = yy[31:0] + zz[31:0];
    pitch_nxt.deg   = '0;
    pitch_nxt.neg   = !accel_x[15];
    pitch_nxt.zero  = (accel_x == 16'sd0);
    pitch_nxt.full  = (accel_y == 16'sd0) && (accel_z == 16'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_r.valid  <= 1'b0;
      pitch_r.valid <= 1'b0;
    end else if (en) begin
      roll_r  <= roll_nxt;
      pitch_r <= pitch_nxt;
    end
  end

  assign roll_o  = roll_r;
  assign pitch_o = pitch_r;

endmodule
`default_nettype wire

/* sv/att_step.sv */
// One binary-search step on the degree count: test (n*C[k])^2 >= den*S[k]^2.
// Two register stages: chunked partial products, then sum and compare. Depends on att_pkg.
`default_nettype none
module att_step #(
  parameter int FRAC_BITS = 24,
  parameter int STEP_BIT  = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  att_pkg::lane_t lane_i,
  output att_pkg::lane_t lane_o
);

  localparam int F   = FRAC_BITS;
  localparam int CW  = 2 * F + 2;
  localparam int NCH = (CW + 31) / 32;
  localparam int SQW = NCH * 32;
  localparam int PW  = SQW + 32;
  localparam logic [att_pkg::DEG_W-1:0] BIT_K = att_pkg::DEG_W'(STEP_BIT);

  typedef logic [SQW-1:0] sq_arr_t [0:att_pkg::TBL_DEPTH-1];

  function automatic sq_arr_t build_sq(input logic want_sin);
    att_pkg::q_arr_t w;
    sq_arr_t         t;
    logic [63:0]     v;
    logic [F:0]      r;
    logic [63:0]     half;
    w    = att_pkg::walk(want_sin);
    half = 64'd1 << (att_pkg::WORK_BITS - F - 1);
    for (int k = 0; k < att_pkg::TBL_DEPTH; k++) begin
      if (k < 90) begin
        v    = (w[k] + half) >> (att_pkg::WORK_BITS - F);
        r    = v[F:0];
        t[k] = SQW'(r) * SQW'(r);
      end else begin
        t[k] = '0;
      end
    end
    return t;
  endfunction

  localparam sq_arr_t CSQ = build_sq(1'b0);
  localparam sq_arr_t SSQ = build_sq(1'b1);

  logic [att_pkg::DEG_W-1:0] cand, cand_r;
  logic                      ok_r;
  logic [SQW-1:0]            csq, ssq;
  logic [63:0]               pc_nxt [NCH];
  logic [63:0]               ps_nxt [NCH];
  logic [63:0]               pc_r   [NCH];
  logic [63:0]               ps_r   [NCH];
  att_pkg::lane_t            a_r, b_nxt, b_r;
  logic [PW-1:0]             lhs, rhs;

  always_comb begin
    cand = lane_i.deg | BIT_K;
    csq  = CSQ[cand];
    ssq  = SSQ[cand];
    for (int i = 0; i < NCH; i++) begin
      pc_nxt[i] = 64'(lane_i.mag2) * 64'(csq[32*i +: 32]);
      ps_nxt[i] = 64'(lane_i.den)  * 64'(ssq[32*i +: 32]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.valid <= 1'b0;
    end else if (en) begin
      a_r <= lane_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cand_r <= cand;
      ok_r   <= (cand <= att_pkg::MAX_DEG);
      pc_r   <= pc_nxt;
      ps_r   <= ps_nxt;
    end
  end

  always_comb begin
    lhs = '0;
    rhs = '0;
    for (int i = 0; i < NCH; i++) begin
      lhs = lhs + (PW'(pc_r[i]) << (32 * i));
      rhs = rhs + (PW'(ps_r[i]) << (32 * i));
    end
    b_nxt = a_r;
    if (ok_r && (lhs >= rhs)) begin
      b_nxt.deg = cand_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else if (en) begin
      b_r <= b_nxt;
    end
  end

  assign lane_o = b_r;

endmodule
`default_nettype wire

/* sv/accel_tilt_angles.sv */
// Top level of the accelerometer tilt-angle pipeline (roll and pitch in whole degrees).
// Uses att_pkg, att_prep and att_step.
//
// Usage:
//   in_*  : one word per sample, tdata = {accel_z, accel_y, accel_x}, signed 16-bit counts.
//   out_* : one word per sample, tdata = {pitch_deg, roll_deg}, signed 8-bit degrees.
//   Each angle is atan2 truncated toward zero, -90..90; a zero numerator axis gives 0.
// Stages: one square stage, seven binary-search steps of two stages each,
//   one output register.
// Throughput: one sample per cycle while the pipeline is not stalled; every
//   stage is a register and the whole pipeline moves together.
// Stall: while out_tvalid is high and out_tready low, the pipeline holds and
//   in_tready drops; nothing is lost or repeated. Empty slots move along with
//   the pipeline and are not squeezed out.
// Reset: clears all valid bits; the block keeps no other state.
`default_nettype none
module accel_tilt_angles #(
  parameter int FRAC_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [47:0] in_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [15:0] out_tdata   // roll_deg[7:0], pitch_deg[15:8]
);

  localparam int NSTEP = 7;

  logic           en;
  att_pkg::lane_t roll_s  [NSTEP+1];
  att_pkg::lane_t pitch_s [NSTEP+1];
  logic           out_valid_r;
  logic [15:0]    out_data_r, out_data_nxt;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  att_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (in_tvalid),
    .accel_x  (in_tdata[15:0]),
    .accel_y  (in_tdata[31:16]),
    .accel_z  (in_tdata[47:32]),
    .roll_o   (roll_s[0]),
    .pitch_o  (pitch_s[0])
  );

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    att_step #(.FRAC_BITS(FRAC_BITS), .STEP_BIT(1 << (NSTEP - 1 - j))) u_roll (
      .clk(clk), .rst_n(rst_n), .en(en), .lane_i(roll_s[j]), .lane_o(roll_s[j+1])
    );
    att_step #(.FRAC_BITS(FRAC_BITS), .STEP_BIT(1 << (NSTEP - 1 - j))) u_pitch (
      .clk(clk), .rst_n(rst_n), .en(en), .lane_i(pitch_s[j]), .lane_o(pitch_s[j+1])
    );
  end

  function automatic logic [7:0] finish(input att_pkg::lane_t l);
    logic [att_pkg::DEG_W-1:0] m;
    logic [7:0]                v;
    m = l.zero ? '0 : (l.full ? att_pkg::RIGHT_DEG : l.deg);
    v = {1'b0, m};
    return (l.neg && !l.zero) ? (8'd0 - v) : v;
  endfunction

  assign out_data_nxt = {finish(pitch_s[NSTEP]), finish(roll_s[NSTEP])};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= roll_s[NSTEP].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
